FILE: rtl/srr_pkg.sv
package srr_pkg;

   localparam int SEQ_MAX_DEFAULT = 7;
   localparam int SEQ_W           = 3;
   localparam int PAYLOAD_W       = 64;
   localparam int QUEUE_DEPTH     = 2;

   typedef enum logic [1:0] {
      KIND_ACK     = 2'd0,
      KIND_NAK     = 2'd1,
      KIND_DELIVER = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ACK,
      ST_DRAIN
   } back_state_type;

   // one queued frame: bad covers both a failed check and a number out of range
   typedef struct packed {
      logic                 bad;
      logic [SEQ_W-1:0]     seq;
      logic [PAYLOAD_W-1:0] low;
      logic [PAYLOAD_W-1:0] high;
   } cmd_type;

endpackage

FILE: rtl/srr_if.sv
interface srr_req_if import srr_pkg::*; ;
   logic                 valid;
   logic                 ready;
   logic [SEQ_W-1:0]     seq;
   logic [PAYLOAD_W-1:0] payload_low;
   logic [PAYLOAD_W-1:0] payload_high;
   logic                 check_ok;

   modport source (output valid, seq, payload_low, payload_high, check_ok, input ready);
   modport sink   (input valid, seq, payload_low, payload_high, check_ok, output ready);
endinterface

interface srr_rsp_if import srr_pkg::*; ;
   logic                 valid;
   logic                 ready;
   logic [1:0]           kind;
   logic [SEQ_W-1:0]     out_seq;
   logic [PAYLOAD_W-1:0] out_low;
   logic [PAYLOAD_W-1:0] out_high;
   logic                 last;

   modport source (output valid, kind, out_seq, out_low, out_high, last, input ready);
   modport sink   (input valid, kind, out_seq, out_low, out_high, last, output ready);
endinterface

FILE: rtl/srr_front.sv
module srr_front import srr_pkg::*; #(
   parameter int SEQ_MAX = SEQ_MAX_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   srr_req_if.sink   req_ch,
   output cmd_type   cmd,
   output logic      cmd_valid,
   input  logic      cmd_pop
);

   localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);

   cmd_type               entry_ff [QUEUE_DEPTH];
   logic [PtrW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]       count_ff, count_in;
   logic                  push;
   logic                  seq_out_of_range;
   cmd_type               new_cmd;

   assign req_ch.ready = (count_ff != CntW'(QUEUE_DEPTH));
   assign push         = req_ch.valid && req_ch.ready;

   assign seq_out_of_range = (32'(req_ch.seq) > 32'(SEQ_MAX));

   always_comb begin
      new_cmd.bad  = !req_ch.check_ok || seq_out_of_range;
      new_cmd.seq  = req_ch.seq;
      new_cmd.low  = req_ch.payload_low;
      new_cmd.high = req_ch.payload_high;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (cmd_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      case ({push, cmd_pop})
         2'b10:   count_in = count_ff + CntW'(1);
         2'b01:   count_in = count_ff - CntW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_cmd;
      end
   end

   assign cmd_valid = (count_ff != '0);
   assign cmd       = entry_ff[rd_ptr_ff];

endmodule

FILE: rtl/srr_ram.sv
module srr_ram #(
   parameter  int WIDTH = 8,
   parameter  int DEPTH = 2,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/srr_back.sv
module srr_back import srr_pkg::*; #(
   parameter int SEQ_MAX = SEQ_MAX_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   input  logic       cmd_valid,
   output logic       cmd_pop,
   srr_rsp_if.source  rsp_ch
);

   localparam int Slots = SEQ_MAX + 1;
   localparam int IdxW  = $clog2(Slots);

   back_state_type        state_ff, state_in;
   logic [IdxW-1:0]       expected_ff, expected_in;
   logic [Slots-1:0]      held_valid_ff, held_valid_in;
   logic [SEQ_W-1:0]      cur_seq_ff, cur_seq_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   kind_type              rsp_kind_ff, rsp_kind_in;
   logic [SEQ_W-1:0]      rsp_seq_ff, rsp_seq_in;
   logic [PAYLOAD_W-1:0]  rsp_low_ff, rsp_low_in;
   logic [PAYLOAD_W-1:0]  rsp_high_ff, rsp_high_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  can_load;
   logic                  load;
   logic [IdxW-1:0]       cmd_idx;
   logic                  in_order;
   logic [IdxW-1:0]       exp_next;

   logic                  ram_we;
   logic                  ram_re;
   logic [IdxW-1:0]       ram_raddr;
   logic [2*PAYLOAD_W-1:0] ram_rdata;

   // output register frees up in the same cycle it is taken
   assign can_load = !rsp_valid_ff || rsp_ch.ready;
   assign cmd_idx  = IdxW'(cmd.seq);
   assign in_order = (cmd_idx == expected_ff);
   assign exp_next = (expected_ff == IdxW'(SEQ_MAX)) ? '0 : expected_ff + IdxW'(1);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && can_load && !cmd.bad && in_order) begin
               state_in = ST_ACK;
            end
         end
         ST_ACK: begin
            if (can_load) begin
               state_in = held_valid_ff[expected_ff] ? ST_DRAIN : ST_IDLE;
            end
         end
         ST_DRAIN: begin
            if (can_load) begin
               state_in = held_valid_ff[exp_next] ? ST_DRAIN : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      load          = 1'b0;
      cmd_pop       = 1'b0;
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      ram_raddr     = expected_ff;
      expected_in   = expected_ff;
      held_valid_in = held_valid_ff;
      cur_seq_in    = cur_seq_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_seq_in    = rsp_seq_ff;
      rsp_low_in    = rsp_low_ff;
      rsp_high_in   = rsp_high_ff;
      rsp_last_in   = rsp_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && can_load) begin
               load    = 1'b1;
               cmd_pop = 1'b1;
               if (cmd.bad) begin
                  rsp_kind_in = KIND_NAK;
                  rsp_seq_in  = '0;
                  rsp_low_in  = '0;
                  rsp_high_in = '0;
                  rsp_last_in = 1'b1;
               end else if (in_order) begin
                  rsp_kind_in            = KIND_DELIVER;
                  rsp_seq_in             = cmd.seq;
                  rsp_low_in             = cmd.low;
                  rsp_high_in            = cmd.high;
                  rsp_last_in            = 1'b0;
                  held_valid_in[cmd_idx] = 1'b0;
                  expected_in            = exp_next;
                  cur_seq_in             = cmd.seq;
               end else begin
                  ram_we                 = 1'b1;
                  held_valid_in[cmd_idx] = 1'b1;
                  rsp_kind_in            = KIND_ACK;
                  rsp_seq_in             = cmd.seq;
                  rsp_low_in             = '0;
                  rsp_high_in            = '0;
                  rsp_last_in            = 1'b1;
               end
            end
         end
         ST_ACK: begin
            if (can_load) begin
               // prefetch the next slot's payload in case the run continues
               load        = 1'b1;
               ram_re      = 1'b1;
               ram_raddr   = expected_ff;
               rsp_kind_in = KIND_ACK;
               rsp_seq_in  = cur_seq_ff;
               rsp_low_in  = '0;
               rsp_high_in = '0;
               rsp_last_in = !held_valid_ff[expected_ff];
            end
         end
         ST_DRAIN: begin
            if (can_load) begin
               load                       = 1'b1;
               ram_re                     = 1'b1;
               ram_raddr                  = exp_next;
               rsp_kind_in                = KIND_DELIVER;
               rsp_seq_in                 = SEQ_W'(expected_ff);
               rsp_low_in                 = ram_rdata[PAYLOAD_W-1:0];
               rsp_high_in                = ram_rdata[2*PAYLOAD_W-1:PAYLOAD_W];
               rsp_last_in                = !held_valid_ff[exp_next];
               held_valid_in[expected_ff] = 1'b0;
               expected_in                = exp_next;
            end
         end
         default: begin
            load = 1'b0;
         end
      endcase
   end

   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         expected_ff   <= '0;
         held_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         expected_ff   <= expected_in;
         held_valid_ff <= held_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_seq_ff  <= cur_seq_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_seq_ff  <= rsp_seq_in;
      rsp_low_ff  <= rsp_low_in;
      rsp_high_ff <= rsp_high_in;
      rsp_last_ff <= rsp_last_in;
   end

   srr_ram #(
      .WIDTH (2 * PAYLOAD_W),
      .DEPTH (Slots)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (cmd_idx),
      .wr_data ({cmd.high, cmd.low}),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.kind     = rsp_kind_ff;
   assign rsp_ch.out_seq  = rsp_seq_ff;
   assign rsp_ch.out_low  = rsp_low_ff;
   assign rsp_ch.out_high = rsp_high_ff;
   assign rsp_ch.last     = rsp_last_ff;

endmodule

FILE: rtl/selective_repeat_reorder_receiver_unit.sv
// Selective-repeat receiver. Each accepted frame lands in a two-word queue; the
// back end then answers it through an output register, one result word per cycle
// while the output is not stalled: a failed or out-of-range frame gives one NAK, an
// out-of-order frame is stored in the payload RAM and gives one ACK, and an
// in-order frame gives its delivery, an ACK and one delivery per stored successor
// in the run (2 + k words for k stored frames, so up to SEQ_MAX + 2). The back end
// reads the store one slot a cycle while the output is not stalled. Slot valid bits
// are cleared by reset; the store needs no clearing pass.
module selective_repeat_reorder_receiver_unit import srr_pkg::*; #(
   parameter int SEQ_MAX = SEQ_MAX_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   srr_req_if.sink   req_ch,
   srr_rsp_if.source rsp_ch
);

   cmd_type cmd;
   logic    cmd_valid;
   logic    cmd_pop;

   srr_front #(
      .SEQ_MAX (SEQ_MAX)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .cmd       (cmd),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop)
   );

   srr_back #(
      .SEQ_MAX (SEQ_MAX)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .rsp_ch    (rsp_ch)
   );

   a_pop_needs_word: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid)
      else $error("queue popped while empty");

   a_bad_gives_nak: assert property (@(posedge clock) disable iff (reset)
      cmd_pop && cmd.bad |=> rsp_ch.valid && rsp_ch.kind == KIND_NAK && rsp_ch.last
                             && rsp_ch.out_seq == '0)
      else $error("bad frame not answered by a single nak");

   a_ack_no_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.kind == KIND_ACK |-> rsp_ch.out_low == '0
                                                  && rsp_ch.out_high == '0)
      else $error("ack word carries payload");

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import srr_pkg::*;

   localparam int SEQ_LIMIT = SEQ_MAX_DEFAULT;
   localparam int SLOT_COUNT = SEQ_LIMIT + 1;

   typedef struct {
      logic [SEQ_W-1:0]     seq;
      logic [PAYLOAD_W-1:0] low;
      logic [PAYLOAD_W-1:0] high;
      logic                 ok;
   } frame_type;

   typedef struct {
      kind_type             kind;
      logic [SEQ_W-1:0]     seq;
      logic [PAYLOAD_W-1:0] low;
      logic [PAYLOAD_W-1:0] high;
      logic                 last;
   } answer_type;

   logic clock = 1'b0;
   logic reset;

   srr_req_if req_ch();
   srr_rsp_if rsp_ch();

   selective_repeat_reorder_receiver_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #5 clock = ~clock;

   // receiver mirror
   logic [SEQ_W-1:0]     next_seq;
   logic                 slot_full [SLOT_COUNT];
   logic [PAYLOAD_W-1:0] slot_low  [SLOT_COUNT];
   logic [PAYLOAD_W-1:0] slot_high [SLOT_COUNT];

   answer_type pending_answers[$];

   int  mismatches     = 0;
   int  frames_sent    = 0;
   int  naks_due       = 0;
   int  deliveries_due = 0;
   int  drained_frames = 0;
   int  longest_burst  = 0;
   bit  sender_idle_en   = 1'b1;
   bit  receiver_idle_en = 1'b1;
   logic hold_off = 1'b0;

   function automatic logic [SEQ_W-1:0] seq_after(input logic [SEQ_W-1:0] n);
      return (n >= SEQ_LIMIT) ? '0 : n + 1'b1;
   endfunction

   function automatic void push_answer(input kind_type k, input logic [SEQ_W-1:0] s,
                                       input logic [PAYLOAD_W-1:0] lo,
                                       input logic [PAYLOAD_W-1:0] hi);
      answer_type a;
      a.kind = k;
      a.seq  = s;
      a.low  = lo;
      a.high = hi;
      a.last = 1'b0;
      pending_answers.insert(pending_answers.size(), a);
   endfunction

   // works out every answer one accepted frame causes and updates the mirror
   function automatic void model_receiver(input frame_type f);
      int count;
      count = 2;
      if (!f.ok || f.seq > SEQ_LIMIT) begin
         push_answer(KIND_NAK, '0, '0, '0);
         naks_due++;
         count = 1;
      end else if (f.seq == next_seq) begin
         push_answer(KIND_DELIVER, f.seq, f.low, f.high);
         push_answer(KIND_ACK, f.seq, '0, '0);
         deliveries_due++;
         slot_full[f.seq] = 1'b0;
         next_seq = seq_after(next_seq);
         while (slot_full[next_seq]) begin
            push_answer(KIND_DELIVER, next_seq, slot_low[next_seq], slot_high[next_seq]);
            slot_full[next_seq] = 1'b0;
            next_seq = seq_after(next_seq);
            deliveries_due++;
            drained_frames++;
            count++;
         end
      end else begin
         slot_full[f.seq] = 1'b1;
         slot_low[f.seq]  = f.low;
         slot_high[f.seq] = f.high;
         push_answer(KIND_ACK, f.seq, '0, '0);
         count = 1;
      end
      pending_answers[$].last = 1'b1;
      if (count > longest_burst) longest_burst = count;
   endfunction

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      mismatches++;
   endtask

   task automatic check_answer();
      answer_type a;
      if (pending_answers.size() == 0) begin
         report_mismatch($sformatf("unexpected word kind=%0d seq=%0d",
                                   rsp_ch.kind, rsp_ch.out_seq));
      end else begin
         a = pending_answers.pop_front();
         if (rsp_ch.kind !== a.kind)
            report_mismatch($sformatf("kind %0d, want %0d", rsp_ch.kind, a.kind));
         if (rsp_ch.out_seq !== a.seq)
            report_mismatch($sformatf("out_seq %0d, want %0d", rsp_ch.out_seq, a.seq));
         if (rsp_ch.out_low !== a.low)
            report_mismatch($sformatf("out_low %h, want %h", rsp_ch.out_low, a.low));
         if (rsp_ch.out_high !== a.high)
            report_mismatch($sformatf("out_high %h, want %h", rsp_ch.out_high, a.high));
         if (rsp_ch.last !== a.last)
            report_mismatch($sformatf("last %b, want %b", rsp_ch.last, a.last));
      end
   endtask

   // result side: check accepted words, then decide ready for the next edge
   int sink_gap = 0;
   always @(posedge clock) begin
      if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) check_answer();
      if (reset || hold_off) begin
         rsp_ch.ready <= 1'b0;
      end else if (sink_gap > 0) begin
         sink_gap--;
         rsp_ch.ready <= 1'b0;
      end else if (receiver_idle_en && $urandom_range(0, 7) == 0) begin
         sink_gap = int'($urandom_range(1, 19)) - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // called at a rising edge; returns at the edge where the word was taken
   task automatic send_frame(input frame_type f);
      if (sender_idle_en && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.seq          <= f.seq;
      req_ch.payload_low  <= f.low;
      req_ch.payload_high <= f.high;
      req_ch.check_ok     <= f.ok;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      model_receiver(f);
      frames_sent++;
   endtask

   function automatic frame_type make_frame(input logic [SEQ_W-1:0] s, input logic ok);
      frame_type f;
      f.seq  = s;
      f.low  = {$urandom(), $urandom()};
      f.high = {$urandom(), $urandom()};
      f.ok   = ok;
      return f;
   endfunction

   // mostly a plausible sender window around the next expected number
   function automatic frame_type random_frame();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 10)
         return make_frame(SEQ_W'($urandom_range(0, SEQ_LIMIT)), 1'b0);
      else if (pick < 45)
         return make_frame(next_seq, 1'b1);
      else if (pick < 85)
         return make_frame(SEQ_W'((next_seq + $urandom_range(1, 3)) % SLOT_COUNT), 1'b1);
      else
         return make_frame(SEQ_W'($urandom_range(0, SEQ_LIMIT)), 1'b1);
   endfunction

   task automatic wait_answers_drained();
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic test_corrupt_frames();
      frame_type f;
      f = make_frame(3'd0, 1'b0);
      f.low  = '1;
      f.high = '1;
      send_frame(f);
      send_frame(make_frame(3'd7, 1'b0));
   endtask

   task automatic test_in_order();
      frame_type f;
      f = make_frame(3'd0, 1'b1);
      f.low  = '0;
      f.high = '0;
      send_frame(f);
      f = make_frame(3'd1, 1'b1);
      f.low  = '1;
      f.high = '1;
      send_frame(f);
   endtask

   // second copy of 4 replaces the first; a bad frame before the good 2 changes nothing
   task automatic test_reorder_overwrite();
      send_frame(make_frame(3'd4, 1'b1));
      send_frame(make_frame(3'd4, 1'b1));
      send_frame(make_frame(3'd3, 1'b1));
      send_frame(make_frame(3'd2, 1'b0));
      send_frame(make_frame(3'd2, 1'b1));
   endtask

   // every slot but the next expected one stored, then the missing one releases the whole window
   task automatic test_full_window();
      logic [SEQ_W-1:0] gap_seq;
      logic [SEQ_W-1:0] s;
      gap_seq = next_seq;
      s = seq_after(gap_seq);
      while (s != gap_seq) begin
         send_frame(make_frame(s, 1'b1));
         s = seq_after(s);
      end
      send_frame(make_frame(gap_seq, 1'b1));
   endtask

   // a copy of an old number is held until the numbers wrap round to it
   task automatic test_stale_copy();
      logic [SEQ_W-1:0] behind;
      behind = SEQ_W'((next_seq + SEQ_LIMIT) % SLOT_COUNT);
      send_frame(make_frame(behind, 1'b1));
      while (seq_after(next_seq) != behind) send_frame(make_frame(next_seq, 1'b1));
      send_frame(make_frame(next_seq, 1'b1));
   endtask

   task automatic test_backpressure();
      fork
         begin
            hold_off <= 1'b1;
            repeat (300) @(posedge clock);
            hold_off <= 1'b0;
         end
         repeat (30) send_frame(random_frame());
      join
   endtask

   task automatic test_random_traffic();
      for (int i = 0; i < 300; i++) begin
         if (i % 25 == 0) begin
            sender_idle_en   = (i < 250) && ($urandom_range(0, 3) != 0);
            receiver_idle_en = (i < 250) && ($urandom_range(0, 3) != 0);
         end
         send_frame(random_frame());
      end
   endtask

   initial begin
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.seq          = '0;
      req_ch.payload_low  = '0;
      req_ch.payload_high = '0;
      req_ch.check_ok     = 1'b0;
      next_seq            = '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         slot_full[i] = 1'b0;
         slot_low[i]  = '0;
         slot_high[i] = '0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_corrupt_frames();
      test_in_order();
      test_reorder_overwrite();
      test_full_window();
      test_stale_copy();
      test_backpressure();
      test_random_traffic();
      req_ch.valid <= 1'b0;
      wait_answers_drained();

      $display("%0d frames sent: %0d naks, %0d deliveries (%0d from the store)",
               frames_sent, naks_due, deliveries_due, drained_frames);
      $display("longest answer burst %0d words, %0d mismatches", longest_burst, mismatches);
      if (mismatches == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("timeout with %0d answers outstanding", pending_answers.size());
      $display("TEST FAILED");
      $finish;
   end

endmodule
